>>> hw/rtl/rtk_pkg.sv
// rtk_pkg: shared types, codes and constants of the rtc timekeeping unit
// no dependencies; used by every module under hw/rtl
`default_nettype none

package rtk_pkg;

  localparam logic [1:0] ACT_EVENT = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;

  localparam int FLAG_PERIODIC_BIT = 6;
  localparam int FLAG_UPDATE_BIT   = 4;

  localparam logic [1:0] CFG_RESYNC_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_THREAD_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_TICK_NS         = 2'd2;

  localparam logic [7:0]  RESYNC_INTERVAL_RST = 8'd37;
  localparam logic [7:0]  THREAD_PERIOD_RST   = 8'd11;
  localparam logic [29:0] TICK_NS_RST         = 30'd976562;

  localparam logic [30:0] NANOS_MAX = 31'h7FFF_FFFF;

  // march based day count
  localparam logic signed [25:0] DAYS_OFFSET   = 26'sd719499;
  localparam logic signed [25:0] DAYS_PER_YEAR = 26'sd365;
  localparam logic [15:0]        MONTH_MUL     = 16'd367;
  // reciprocals: x/100 = (x*5243)>>19, x/3 = (x*43691)>>17 over the ranges used
  localparam logic [27:0]        RECIP_100     = 28'd5243;
  localparam logic [29:0]        RECIP_3       = 30'd43691;
  localparam logic signed [43:0] SECS_PER_DAY  = 44'sd86400;

  typedef enum logic [1:0] {
    KIND_EVENT,
    KIND_SET,
    KIND_GET
  } rtk_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_DAYS,
    ST_SECS,
    ST_DONE
  } rtk_state_t;

  typedef struct packed {
    rtk_kind_t          kind;
    logic               periodic;
    logic               update;
    logic signed [15:0] year;    // march based, may be -1
    logic [7:0]         month;   // march based, 1 .. 163
    logic [7:0]         day;
    logic [19:0]        hms;     // hour, minute, second folded into seconds
    logic [63:0]        set_second;
    logic [30:0]        set_nanosecond;
  } rtk_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rtk_qstat_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    bcd_to_bin = {4'b0, v[3:0]} + 8'(v[7:4]) * 8'd10;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rtk_front.sv
// rtk_front: accepts input requests, decodes action and bcd calendar fields
// depends on rtk_pkg; feeds rtk_queue
`default_nettype none

module rtk_front (
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [159:0]       in_tdata,
  input  wire logic [1:0]         in_tuser,
  input  wire rtk_pkg::rtk_qstat_t q_stat,
  output logic                    push,
  output rtk_pkg::rtk_item_t      push_item
);

  logic [7:0]         century_bin;
  logic [7:0]         year_bin;
  logic [7:0]         month_bin;
  logic [7:0]         hour_bin;
  logic [7:0]         minute_bin;
  logic [7:0]         second_bin;
  logic [15:0]        full_year;
  logic signed [15:0] year_s;

  assign century_bin = rtk_pkg::bcd_to_bin(in_tdata[15:8]);
  assign year_bin    = rtk_pkg::bcd_to_bin(in_tdata[23:16]);
  assign month_bin   = rtk_pkg::bcd_to_bin(in_tdata[31:24]);
  assign hour_bin    = rtk_pkg::bcd_to_bin(in_tdata[47:40]);
  assign minute_bin  = rtk_pkg::bcd_to_bin(in_tdata[55:48]);
  assign second_bin  = rtk_pkg::bcd_to_bin(in_tdata[63:56]);

  assign full_year = 16'(century_bin) * 16'd100 + 16'(year_bin);
  assign year_s    = $signed(full_year);

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    case (in_tuser)
      rtk_pkg::ACT_EVENT: push_item.kind = rtk_pkg::KIND_EVENT;
      rtk_pkg::ACT_SET:   push_item.kind = rtk_pkg::KIND_SET;
      default:            push_item.kind = rtk_pkg::KIND_GET;
    endcase
    push_item.periodic = in_tdata[rtk_pkg::FLAG_PERIODIC_BIT];
    push_item.update   = in_tdata[rtk_pkg::FLAG_UPDATE_BIT];
    // january, february and month zero count as months of the year before
    if (month_bin <= 8'd2) begin
      push_item.month = month_bin + 8'd10;
      push_item.year  = year_s - 16'sd1;
    end else begin
      push_item.month = month_bin - 8'd2;
      push_item.year  = year_s;
    end
    push_item.day = rtk_pkg::bcd_to_bin(in_tdata[39:32]);
    push_item.hms = 20'(hour_bin) * 20'd3600 + 20'(minute_bin) * 20'd60 + 20'(second_bin);
    push_item.set_second     = in_tdata[127:64];
    push_item.set_nanosecond = in_tdata[158:128];
  end

endmodule

`default_nettype wire

>>> hw/rtl/rtk_queue.sv
// rtk_queue: short fifo of decoded requests between front and back
// depends on rtk_pkg
`default_nettype none

module rtk_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rtk_pkg::rtk_item_t  push_item,
  input  wire logic                pop,
  output rtk_pkg::rtk_item_t       head_item,
  output rtk_pkg::rtk_qstat_t      q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtk_pkg::rtk_item_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_item    = entry_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rtk_back.sv
// rtk_back: executes requests, keeps the time state and runs the calendar sequencer
// depends on rtk_pkg; takes requests from rtk_queue, drives the result channel
`default_nettype none

module rtk_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [29:0]         cfg_wdata,
  input  wire rtk_pkg::rtk_item_t  head_item,
  input  wire rtk_pkg::rtk_qstat_t q_stat,
  output logic                     pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [95:0]              out_tdata
);

  rtk_pkg::rtk_state_t state_r, state_nxt;
  rtk_pkg::rtk_item_t  item_r;
  rtk_pkg::rtk_item_t  cur;

  logic [7:0]  resync_interval_r;
  logic [7:0]  thread_period_r;
  logic [29:0] tick_ns_r;

  logic [63:0] sec_r, sec_nxt;
  logic [30:0] ns_r, ns_nxt;
  logic [7:0]  resync_cnt_r, resync_cnt_nxt;
  logic [7:0]  thread_cnt_r, thread_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_sec_r;
  logic [30:0]        out_ns_r;
  logic               out_pulse_r;
  logic               pulse;

  logic [27:0]        prod100_r;
  logic [15:0]        prod367_r;
  logic [7:0]         q100_r;
  logic [29:0]        mq_r;
  logic signed [25:0] days_r;
  logic signed [43:0] secs_r;

  logic               year_neg;
  logic [14:0]        year_u;
  logic signed [25:0] leaps;
  logic signed [25:0] days_nxt;
  logic signed [43:0] secs_nxt;
  logic [31:0]        ns_sum;
  logic [30:0]        ns_tick;

  logic out_free;
  logic cal_path;
  logic commit;
  logic load_item;

  assign out_free   = !out_valid_r || out_tready;
  assign cur        = (state_r == rtk_pkg::ST_DONE) ? item_r : head_item;
  assign cal_path   = (cur.kind == rtk_pkg::KIND_EVENT) && cur.update && (resync_cnt_r == '0);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pulse_r, out_ns_r, out_sec_r};

  // calendar datapath
  assign year_neg = item_r.year[15];
  assign year_u   = year_neg ? '0 : item_r.year[14:0];
  assign leaps    = year_neg ? -26'sd1
                  : $signed(26'(year_u[14:2])) - $signed(26'(q100_r))
                    + $signed(26'(q100_r[7:2]));
  assign days_nxt = leaps + $signed(26'(mq_r[29:17])) + $signed(26'(item_r.day))
                  + $signed({{10{item_r.year[15]}}, item_r.year}) * rtk_pkg::DAYS_PER_YEAR
                  - rtk_pkg::DAYS_OFFSET;
  assign secs_nxt = $signed({{18{days_r[25]}}, days_r}) * rtk_pkg::SECS_PER_DAY
                  + $signed({24'b0, item_r.hms});

  assign ns_sum  = 32'(ns_r) + 32'(tick_ns_r);
  assign ns_tick = ns_sum[31] ? rtk_pkg::NANOS_MAX : ns_sum[30:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtk_pkg::ST_IDLE: begin
        if (!q_stat.empty && cal_path) state_nxt = rtk_pkg::ST_MUL;
      end
      rtk_pkg::ST_MUL:  state_nxt = rtk_pkg::ST_QUO;
      rtk_pkg::ST_QUO:  state_nxt = rtk_pkg::ST_DAYS;
      rtk_pkg::ST_DAYS: state_nxt = rtk_pkg::ST_SECS;
      rtk_pkg::ST_SECS: state_nxt = rtk_pkg::ST_DONE;
      rtk_pkg::ST_DONE: begin
        if (out_free) state_nxt = rtk_pkg::ST_IDLE;
      end
      default: state_nxt = rtk_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop       = 1'b0;
    commit    = 1'b0;
    load_item = 1'b0;
    case (state_r)
      rtk_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          if (cal_path) begin
            pop       = 1'b1;
            load_item = 1'b1;
          end else if (out_free) begin
            pop    = 1'b1;
            commit = 1'b1;
          end
        end
      end
      rtk_pkg::ST_DONE: commit = out_free;
      default: ;
    endcase
  end

  // time state update
  always_comb begin
    sec_nxt        = sec_r;
    ns_nxt         = ns_r;
    resync_cnt_nxt = resync_cnt_r;
    thread_cnt_nxt = thread_cnt_r;
    pulse          = 1'b0;
    if (commit) begin
      case (cur.kind)
        rtk_pkg::KIND_EVENT: begin
          if (cur.periodic) ns_nxt = ns_tick;
          if (cur.update) begin
            if (resync_cnt_r != '0) begin
              resync_cnt_nxt = resync_cnt_r - 8'd1;
              sec_nxt        = sec_r + 64'd1;
            end else begin
              sec_nxt        = {{20{secs_r[43]}}, secs_r};
              resync_cnt_nxt = resync_interval_r;
            end
            ns_nxt = '0;
          end
          if (thread_cnt_r == '0) begin
            thread_cnt_nxt = thread_period_r;
            pulse          = 1'b1;
          end else begin
            thread_cnt_nxt = thread_cnt_r - 8'd1;
          end
        end
        rtk_pkg::KIND_SET: begin
          sec_nxt = cur.set_second;
          ns_nxt  = cur.set_nanosecond;
        end
        default: ;
      endcase
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= rtk_pkg::ST_IDLE;
      resync_interval_r <= rtk_pkg::RESYNC_INTERVAL_RST;
      thread_period_r   <= rtk_pkg::THREAD_PERIOD_RST;
      tick_ns_r         <= rtk_pkg::TICK_NS_RST;
      sec_r             <= '0;
      ns_r              <= '0;
      resync_cnt_r      <= '0;
      thread_cnt_r      <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sec_r        <= sec_nxt;
      ns_r         <= ns_nxt;
      resync_cnt_r <= resync_cnt_nxt;
      thread_cnt_r <= thread_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          rtk_pkg::CFG_RESYNC_INTERVAL: resync_interval_r <= cfg_wdata[7:0];
          rtk_pkg::CFG_THREAD_PERIOD:   thread_period_r   <= cfg_wdata[7:0];
          rtk_pkg::CFG_TICK_NS:         tick_ns_r         <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) item_r <= head_item;
    if (commit) begin
      out_sec_r   <= sec_nxt;
      out_ns_r    <= ns_nxt;
      out_pulse_r <= pulse;
    end
    prod100_r <= 28'(year_u) * rtk_pkg::RECIP_100;
    prod367_r <= 16'(item_r.month) * rtk_pkg::MONTH_MUL;
    q100_r    <= prod100_r[26:19];
    mq_r      <= 30'(prod367_r[15:2]) * rtk_pkg::RECIP_3;
    days_r    <= days_nxt;
    secs_r    <= secs_nxt;
  end

`ifndef ASSERT_OFF
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == rtk_pkg::ST_IDLE))
    else $error("request taken outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> out_free)
    else $error("pending result overwritten");

  a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtk_pkg::ST_MUL) |=> (state_r == rtk_pkg::ST_QUO) ##1
    (state_r == rtk_pkg::ST_DAYS) ##1 (state_r == rtk_pkg::ST_SECS))
    else $error("calendar sequence broken");

  a_update_clears_ns: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cur.kind == rtk_pkg::KIND_EVENT && cur.update) |=> (ns_r == '0))
    else $error("update left nanoseconds nonzero");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rtc_timekeeping_unit.sv
// rtc_timekeeping_unit: top level, wall clock seconds and nanoseconds from rtc interrupts
// depends on rtk_pkg, rtk_front, rtk_queue, rtk_back
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tdata 160b, in_tuser 2b (action)
// out_     out  out_tvalid/out_tready  out_tdata 96b
// cfg_     in   cfg_wr_en              cfg_index 2b, cfg_wdata 30b
//
// interrupt, set and get requests off the calendar path leave the queue and reach the
// registered output as soon as the output is free; an update that resyncs from the
// calendar runs the sequencer steps take, multiply, quotient, days, seconds, done
// synchronous active-low reset clears time, countdowns and restores config defaults
// the queue keeps accepting while the back end waits on out_tready, until its
// QUEUE_DEPTH entries are full and in_tready drops
`default_nettype none

module rtc_timekeeping_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // action
  input  wire logic [1:0]   in_tuser,
  // status_flags, century_bcd, year_bcd, month_bcd, day_bcd, hour_bcd,
  // minute_bcd, second_bcd, set_second, set_nanosecond, zero pad
  input  wire logic [159:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // epoch_second, fraction_ns, schedule_thread
  output logic [95:0]       out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [29:0]  cfg_wdata
);

  rtk_pkg::rtk_item_t  push_item;
  rtk_pkg::rtk_item_t  head_item;
  rtk_pkg::rtk_qstat_t q_stat;
  logic                push;
  logic                pop;

  rtk_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  rtk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  rtk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_item  (head_item),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
